>>> src/ad2f_pkg.sv
// Shared types and constants for the ASCII decimal to fixed-point converter.
// No dependencies.
package ad2f_pkg;

    localparam int OUT_W = 40;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_DOT   = 8'h2e;
    localparam logic [7:0] CHAR_COMMA = 8'h2c;

    typedef enum logic [3:0] {
        PH_BEFORE = 4'b0001,
        PH_INT    = 4'b0010,
        PH_FRAC   = 4'b0100,
        PH_DONE   = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [OUT_W-1:0] fixed_value;
        logic             digit_found;
        logic             saturated;
    } result_t;

endpackage

>>> src/ad2f_parse.sv
// Parse state and per-character update logic; builds the result on end of string.
// Depends on ad2f_pkg.
module ad2f_parse #(
    parameter int INT_BITS    = 24,
    parameter int FRAC_BITS   = 16,
    parameter int FRAC_DIGITS = 4,
    parameter int MAX_CHARS   = 200
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          char_byte,
    input  logic                end_of_string,
    output ad2f_pkg::result_t   result
);
    import ad2f_pkg::*;

    localparam int CH_W    = $clog2(MAX_CHARS + 1);
    localparam int CNT_W   = $clog2(FRAC_DIGITS + 1);
    localparam int IDX_W   = (FRAC_DIGITS > 1) ? $clog2(FRAC_DIGITS) : 1;
    localparam int W_DEPTH = 1 << IDX_W;
    localparam int V_W     = INT_BITS + 4;
    localparam int SUM_W   = FRAC_BITS + 4;
    localparam int WIDE_W  = (INT_BITS + FRAC_BITS > OUT_W) ? INT_BITS + FRAC_BITS : OUT_W;

    localparam logic [INT_BITS-1:0]  INT_MAX  = {INT_BITS{1'b1}};
    localparam logic [FRAC_BITS-1:0] FRAC_MAX = {FRAC_BITS{1'b1}};

    logic [FRAC_BITS-1:0] weight [W_DEPTH];

    genvar k;
    generate
        for (k = 0; k < W_DEPTH; k++)
        begin : g_weight
            localparam longint unsigned P  = 64'd10 ** (k + 1);
            localparam longint unsigned WV = (k < FRAC_DIGITS) ?
                (((64'd1 << (FRAC_BITS + 1)) + P) / (64'd2 * P)) : 64'd0;
            assign weight[k] = FRAC_BITS'(WV);
        end
    endgenerate

    phase_t               phase_reg, phase_next;
    logic [INT_BITS-1:0]  int_reg, int_next;
    logic [FRAC_BITS-1:0] frac_reg, frac_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [CH_W-1:0]      chars_reg, chars_next;
    logic                 ovf_reg, ovf_next;

    logic                 is_digit;
    logic [3:0]           digit;
    logic [V_W-1:0]       int_ext;
    logic [V_W-1:0]       int_v;
    logic [SUM_W-1:0]     frac_sum;
    logic [WIDE_W-1:0]    wide;

    assign is_digit = (char_byte >= CHAR_ZERO) && (char_byte <= CHAR_NINE);
    assign digit    = is_digit ? 4'(char_byte - CHAR_ZERO) : 4'd0;
    assign int_ext  = V_W'(int_reg);
    assign int_v    = (int_ext << 3) + (int_ext << 1) + V_W'(digit);
    assign frac_sum = SUM_W'(frac_reg)
                    + SUM_W'(digit) * SUM_W'(weight[cnt_reg[IDX_W-1:0]]);

    always_comb
    begin
        phase_next = phase_reg;
        int_next   = int_reg;
        frac_next  = frac_reg;
        cnt_next   = cnt_reg;
        chars_next = chars_reg;
        ovf_next   = ovf_reg;
        result     = '0;

        if (chars_reg >= CH_W'(MAX_CHARS))
        begin
            if (phase_reg != PH_BEFORE)
            begin
                phase_next = PH_DONE;
            end
        end
        else
        begin
            chars_next = chars_reg + CH_W'(1);
            if (phase_reg == PH_DONE)
            begin
            end
            else if (char_byte == CHAR_NUL)
            begin
                if (phase_reg != PH_BEFORE)
                begin
                    phase_next = PH_DONE;
                end
                else
                begin
                    chars_next = CH_W'(MAX_CHARS);
                end
            end
            else
            begin
                case (phase_reg)
                    PH_BEFORE:
                    begin
                        if (is_digit)
                        begin
                            int_next   = INT_BITS'(digit);
                            phase_next = PH_INT;
                        end
                    end
                    PH_INT:
                    begin
                        if (is_digit)
                        begin
                            if (ovf_reg || (int_v > V_W'(INT_MAX)))
                            begin
                                int_next = INT_MAX;
                                ovf_next = 1'b1;
                            end
                            else
                            begin
                                int_next = int_v[INT_BITS-1:0];
                            end
                        end
                        else if ((char_byte == CHAR_DOT) || (char_byte == CHAR_COMMA))
                        begin
                            phase_next = PH_FRAC;
                        end
                        else
                        begin
                            phase_next = PH_DONE;
                        end
                    end
                    PH_FRAC:
                    begin
                        if (is_digit)
                        begin
                            if (cnt_reg < CNT_W'(FRAC_DIGITS))
                            begin
                                cnt_next = cnt_reg + CNT_W'(1);
                                if (frac_sum > SUM_W'(FRAC_MAX))
                                begin
                                    frac_next = FRAC_MAX;
                                end
                                else
                                begin
                                    frac_next = frac_sum[FRAC_BITS-1:0];
                                end
                            end
                        end
                        else
                        begin
                            phase_next = PH_DONE;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end

        wide = WIDE_W'({int_next, frac_next});
        if (phase_next != PH_BEFORE)
        begin
            result.fixed_value = wide[OUT_W-1:0];
            result.digit_found = 1'b1;
            result.saturated   = ovf_next;
        end

        if (end_of_string)
        begin
            phase_next = PH_BEFORE;
            int_next   = '0;
            frac_next  = '0;
            cnt_next   = '0;
            chars_next = '0;
            ovf_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_BEFORE;
            int_reg   <= '0;
            frac_reg  <= '0;
            cnt_reg   <= '0;
            chars_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            int_reg   <= int_next;
            frac_reg  <= frac_next;
            cnt_reg   <= cnt_next;
            chars_reg <= chars_next;
            ovf_reg   <= ovf_next;
        end
    end

    a_before_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_BEFORE) |-> (int_reg == '0) && (frac_reg == '0)
                                     && (cnt_reg == '0) && !ovf_reg)
        else $error("accumulators not clear before first digit");

    a_ovf_max: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> (int_reg == INT_MAX))
        else $error("overflow flag set without clamped integer");

    a_cnt_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != '0) |-> (phase_reg == PH_FRAC) || (phase_reg == PH_DONE))
        else $error("fraction digits counted outside fraction");

endmodule

>>> src/ad2f_out_reg.sv
// Result register for the master-side stream; holds a beat until taken.
// Depends on ad2f_pkg.
module ad2f_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  ad2f_pkg::result_t load_data,
    input  logic              m_tready,
    output logic              m_tvalid,
    output ad2f_pkg::result_t data
);
    import ad2f_pkg::*;

    logic    valid_reg, valid_next;
    result_t data_reg;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

    assign m_tvalid = valid_reg;
    assign data     = data_reg;

endmodule

>>> src/ascii_decimal_to_fixed_top.sv
// Result path: the tlast beat is registered in the input stage; once processed, its result loads the result register.
// Throughput: one character beat per cycle while the input is not stalled by a blocked result.
// A stalled result holds a tlast beat in the input stage and stalls the input behind it; other beats keep flowing.
// Reset: rst_n asynchronous, active low; clears parse state and both valid flags.
// Top level; depends on ad2f_pkg, ad2f_parse, ad2f_out_reg.
module ascii_decimal_to_fixed_top #(
    parameter int INT_BITS    = 24,
    parameter int FRAC_BITS   = 16,
    parameter int FRAC_DIGITS = 4,
    parameter int MAX_CHARS   = 200
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_byte
    input  logic        s_tlast,   // end_of_string
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [39:0] fixed_value
    output logic [1:0]  m_tuser    // [0] digit_found, [1] saturated
);
    import ad2f_pkg::*;

    logic       s1_valid_reg, s1_valid_next;
    logic [7:0] s1_char_reg;
    logic       s1_last_reg;
    logic       s_accept;
    logic       proc;
    result_t    parse_result;
    result_t    out_data;

    assign proc     = s1_valid_reg && (!s1_last_reg || !m_tvalid || m_tready);
    assign s_tready = !s1_valid_reg || proc;
    assign s_accept = s_tvalid && s_tready;

    always_comb
    begin
        if (s_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (proc)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_char_reg <= s_tdata;
            s1_last_reg <= s_tlast;
        end
    end

    ad2f_parse #(
        .INT_BITS    (INT_BITS),
        .FRAC_BITS   (FRAC_BITS),
        .FRAC_DIGITS (FRAC_DIGITS),
        .MAX_CHARS   (MAX_CHARS)
    ) u_parse (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (proc),
        .char_byte     (s1_char_reg),
        .end_of_string (s1_last_reg),
        .result        (parse_result)
    );

    ad2f_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (proc && s1_last_reg),
        .load_data (parse_result),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .data      (out_data)
    );

    assign m_tdata = out_data.fixed_value;
    assign m_tuser = {out_data.saturated, out_data.digit_found};

    a_out_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(proc && s1_last_reg))
        else $error("result beat without a processed tlast beat");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> s1_valid_reg && s1_last_reg && m_tvalid && !m_tready)
        else $error("input stalled without a blocked result");

    a_no_digit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0) && !m_tuser[1])
        else $error("nonzero result without a digit");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// Testbench for ascii_decimal_to_fixed_top: streams reply strings one character per beat
// and checks each parsed fixed-point result against an in-bench parser. Uses ad2f_pkg.
module testbench;

    import ad2f_pkg::*;

    localparam int INT_BITS    = 24;
    localparam int FRAC_BITS   = 16;
    localparam int FRAC_DIGITS = 4;
    localparam int MAX_CHARS   = 200;
    localparam int STALL_LIMIT = 2000;

    localparam longint unsigned INT_MAX  = (64'd1 << INT_BITS) - 1;
    localparam longint unsigned FRAC_MAX = (64'd1 << FRAC_BITS) - 1;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;

    phase_t                 scan_phase;
    logic [INT_BITS-1:0]    int_acc;
    logic [FRAC_BITS-1:0]   frac_acc;
    int                     frac_count;
    int                     char_count;
    bit                     int_overflow;

    result_t    expected_results[$];
    logic [7:0] line_buf[$];

    bit idle_on;
    int errors;
    int lines_sent;
    int chars_sent;
    int results_checked;
    int saturated_seen;
    int empty_seen;
    int stall_cycles;

    ascii_decimal_to_fixed_top #(
        .INT_BITS    (INT_BITS),
        .FRAC_BITS   (FRAC_BITS),
        .FRAC_DIGITS (FRAC_DIGITS),
        .MAX_CHARS   (MAX_CHARS)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint unsigned frac_weight(int k);
        longint unsigned p;
        p = 1;
        for (int i = 0; i < k; i++)
            p = p * 10;
        return ((64'd1 << (FRAC_BITS + 1)) + p) / (2 * p);
    endfunction

    function void clear_scan();
        scan_phase   = PH_BEFORE;
        int_acc      = '0;
        frac_acc     = '0;
        frac_count   = 0;
        char_count   = 0;
        int_overflow = 1'b0;
    endfunction

    function void parse_char(logic [7:0] c, logic eos);
        logic            is_digit;
        longint unsigned d;
        longint unsigned v;
        result_t         r;
        is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
        d = is_digit ? 64'(c - CHAR_ZERO) : 64'd0;
        if (char_count >= MAX_CHARS)
        begin
            if (scan_phase != PH_BEFORE)
                scan_phase = PH_DONE;
        end
        else
        begin
            char_count++;
            if (scan_phase == PH_DONE)
                ;
            else if (c == CHAR_NUL)
            begin
                if (scan_phase != PH_BEFORE)
                    scan_phase = PH_DONE;
                else
                    char_count = MAX_CHARS;
            end
            else
            begin
                case (scan_phase)
                    PH_BEFORE:
                    begin
                        if (is_digit)
                        begin
                            int_acc    = INT_BITS'(d);
                            scan_phase = PH_INT;
                        end
                    end
                    PH_INT:
                    begin
                        if (is_digit)
                        begin
                            if (int_overflow)
                                int_acc = INT_BITS'(INT_MAX);
                            else
                            begin
                                v = longint'(int_acc) * 10 + d;
                                if (v > INT_MAX)
                                begin
                                    int_acc      = INT_BITS'(INT_MAX);
                                    int_overflow = 1'b1;
                                end
                                else
                                    int_acc = INT_BITS'(v);
                            end
                        end
                        else if (c == CHAR_DOT || c == CHAR_COMMA)
                            scan_phase = PH_FRAC;
                        else
                            scan_phase = PH_DONE;
                    end
                    default:
                    begin
                        if (is_digit)
                        begin
                            if (frac_count < FRAC_DIGITS)
                            begin
                                frac_count++;
                                v = longint'(frac_acc) + d * frac_weight(frac_count);
                                frac_acc = (v > FRAC_MAX) ? FRAC_BITS'(FRAC_MAX)
                                                          : FRAC_BITS'(v);
                            end
                        end
                        else
                            scan_phase = PH_DONE;
                    end
                endcase
            end
        end
        if (eos)
        begin
            r.digit_found = (scan_phase != PH_BEFORE);
            r.fixed_value = r.digit_found ? {int_acc, frac_acc} : '0;
            r.saturated   = r.digit_found ? int_overflow : 1'b0;
            expected_results.push_back(r);
            clear_scan();
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            parse_char(s_tdata, s_tlast);
    end

    always @(posedge clk)
    begin : check_result
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result beat: fixed_value %h tuser %b", m_tdata, m_tuser);
                errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                results_checked++;
                if (want.saturated)
                    saturated_seen++;
                if (!want.digit_found)
                    empty_seen++;
                if (m_tdata !== want.fixed_value)
                begin
                    $error("fixed_value: expected %h, actual %h", want.fixed_value, m_tdata);
                    errors++;
                end
                if (m_tuser[0] !== want.digit_found)
                begin
                    $error("digit_found: expected %b, actual %b", want.digit_found, m_tuser[0]);
                    errors++;
                end
                if (m_tuser[1] !== want.saturated)
                begin
                    $error("saturated: expected %b, actual %b", want.saturated, m_tuser[1]);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        m_tready <= 1'b0;
        do
            @(posedge clk);
        while (!rst_n);
        forever
        begin
            if (idle_on && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
        end
    end

    task automatic send_char(logic [7:0] c, logic last);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        chars_sent++;
    endtask

    task automatic send_line();
        int n;
        n = line_buf.size();
        for (int i = 0; i < n; i++)
            send_char(line_buf[i], i == n - 1);
        line_buf.delete();
        lines_sent++;
    endtask

    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    function void add_text(string s);
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
    endfunction

    function automatic logic [7:0] pick_nondigit();
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (c >= CHAR_ZERO && c <= CHAR_NINE);
        return c;
    endfunction

    function automatic logic [7:0] pick_digit();
        return CHAR_ZERO + 8'($urandom_range(0, 9));
    endfunction

    task automatic send_text(string s);
        add_text(s);
        send_line();
    endtask

    task automatic test_directed();
        send_text("0");
        send_text("16777215");
        send_text("16777216");
        send_text("99999999999.75");
        send_text("T=23.5C");
        send_text("1,25");
        send_text("0.9999");
        send_text("3.141592");
        send_text(".5");
        send_text("abc");
        send_text("12.3x45");
        send_text("7.");
        send_text("9");
        send_text("8");
        line_buf.push_back(CHAR_NUL);
        add_text("42");
        send_line();
        add_text("42");
        line_buf.push_back(CHAR_NUL);
        add_text("7");
        send_line();
        line_buf.push_back(8'hff);
        line_buf.push_back(8'h80);
        add_text("65535.0001");
        send_line();
    endtask

    task automatic test_char_limit();
        repeat (MAX_CHARS - 1) line_buf.push_back("a");
        add_text("56");
        send_line();
        repeat (MAX_CHARS) line_buf.push_back(" ");
        add_text("9");
        send_line();
        add_text("3.");
        repeat (250) line_buf.push_back(pick_digit());
        send_line();
    endtask

    task automatic build_reply();
        int n;
        n = $urandom_range(0, 4);
        repeat (n) line_buf.push_back(pick_nondigit());
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 12) : $urandom_range(1, 7);
        repeat (n) line_buf.push_back(pick_digit());
        if ($urandom_range(0, 2) != 0)
        begin
            line_buf.push_back($urandom_range(0, 1) ? CHAR_DOT : CHAR_COMMA);
            n = $urandom_range(0, 6);
            repeat (n) line_buf.push_back(pick_digit());
        end
        n = $urandom_range(0, 3);
        repeat (n) line_buf.push_back(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 11) == 0)
            line_buf.insert($urandom_range(0, line_buf.size()), CHAR_NUL);
    endtask

    task automatic test_random_replies(int char_target);
        int start;
        start = chars_sent;
        while (chars_sent - start < char_target)
        begin
            build_reply();
            send_line();
            if ($urandom_range(0, 29) == 0)
                wait_results_drained();
        end
    endtask

    task automatic test_noise(int char_target);
        int start;
        int n;
        start = chars_sent;
        while (chars_sent - start < char_target)
        begin
            n = $urandom_range(1, 12);
            repeat (n)
            begin
                if ($urandom_range(0, 3) == 0)
                    line_buf.push_back(pick_digit());
                else
                    line_buf.push_back(8'($urandom_range(0, 255)));
            end
            send_line();
        end
    endtask

    initial
    begin
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tlast  <= 1'b0;
        idle_on  = 1'b1;
        clear_scan();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        wait_results_drained();
        test_char_limit();
        test_random_replies(400);
        test_noise(150);
        idle_on = 1'b0;
        test_random_replies(150);
        idle_on = 1'b1;
        test_random_replies(150);
        idle_on = 1'b0;
        test_random_replies(150);

        wait_results_drained();
        repeat (10) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_results.size());
            errors++;
        end
        $display("Parsed %0d strings of %0d characters; %0d results compared.",
                 lines_sent, chars_sent, results_checked);
        $display("Results with clamped integer: %0d, with no number: %0d.",
                 saturated_seen, empty_seen);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
